// ----- sv/ssfl_pkg.sv -----
// Shared types, field widths and codes of the slot store with free list.
`timescale 1ns / 1ps

package ssfl_pkg;

    localparam int SLOT_COUNT_DEF = 1024;

    localparam int OP_W     = 2;
    localparam int VALUE_W  = 32;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;
    localparam int LIVE_W   = 11;
    localparam int SUM_W    = 64;

    typedef enum logic [OP_W-1:0] {
        OP_INSERT      = 2'd0,
        OP_ERASE_AT    = 2'd1,
        OP_ERASE_FIRST = 2'd2,
        OP_SUM         = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_FULL      = 2'd1,
        ST_BAD_SLOT  = 2'd2,
        ST_NONE_LIVE = 2'd3
    } t_status;

endpackage

// ----- sv/ssfl_req_if.sv -----
// Request channel of the slot store: one operation per transaction.
`timescale 1ns / 1ps

interface ssfl_req_if;

    logic                                valid;
    logic                                ready;
    ssfl_pkg::t_op                       operation;
    logic signed [ssfl_pkg::VALUE_W-1:0] value;
    logic [ssfl_pkg::INDEX_W-1:0]        slot_index;

    modport source (
        output valid,
        input  ready,
        output operation,
        output value,
        output slot_index
    );

    modport sink (
        input  valid,
        output ready,
        input  operation,
        input  value,
        input  slot_index
    );

endinterface

// ----- sv/ssfl_rsp_if.sv -----
// Response channel of the slot store: one result per transaction.
`timescale 1ns / 1ps

interface ssfl_rsp_if;

    logic                          valid;
    logic                          ready;
    ssfl_pkg::t_status             status;
    logic [ssfl_pkg::INDEX_W-1:0]  slot_used;
    logic [ssfl_pkg::LIVE_W-1:0]   live_total;
    logic [ssfl_pkg::SUM_W-1:0]    value_sum;

    modport source (
        output valid,
        input  ready,
        output status,
        output slot_used,
        output live_total,
        output value_sum
    );

    modport sink (
        input  valid,
        output ready,
        input  status,
        input  slot_used,
        input  live_total,
        input  value_sum
    );

endinterface

// ----- sv/slot_store_with_free_list.sv -----
// Path, request accepted to response valid: append insert, full insert, out-of-range erase-at
// and empty-store scans go straight from idle to emit; insert from free list passes the pop
// state and erase-at the check state; erase-first and sum pass the scan, at most up to the high-water mark.
// One transaction at a time: a new request is taken only in the idle state. The scan
// walks one slot per cycle through one memory read port and one 64-bit accumulator.
// A response held by o_rsp.ready stalls the emit step. Reset clears counts, high-water mark
// and handshakes at once; no clearing pass, slots beyond the high-water mark are never read.
`timescale 1ns / 1ps

module slot_store_with_free_list #(
    parameter int SLOT_COUNT = ssfl_pkg::SLOT_COUNT_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    ssfl_req_if.sink          i_req,
    ssfl_rsp_if.source        o_rsp
);

    localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W = $clog2(SLOT_COUNT + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_POP,
        S_CHK,
        S_SCAN,
        S_EMIT
    } t_state;

    logic signed [ssfl_pkg::VALUE_W-1:0] r_val_mem   [SLOT_COUNT];
    logic                                r_alive_mem [SLOT_COUNT];
    logic [IDX_W-1:0]                    r_stk_mem   [SLOT_COUNT];

    logic signed [ssfl_pkg::VALUE_W-1:0] r_vmem_q;
    logic                                r_alive_q;
    logic [IDX_W-1:0]                    r_stk_q;

    logic                                val_we;
    logic [IDX_W-1:0]                    val_waddr;
    logic signed [ssfl_pkg::VALUE_W-1:0] val_wdata;
    logic                                alive_we;
    logic [IDX_W-1:0]                    alive_waddr;
    logic                                alive_wdata;
    logic                                rd_en;
    logic [IDX_W-1:0]                    rd_addr;
    logic                                stk_we;
    logic [IDX_W-1:0]                    stk_waddr;
    logic [IDX_W-1:0]                    stk_wdata;
    logic                                stk_re;
    logic [IDX_W-1:0]                    stk_raddr;

    t_state                              r_state,      n_state;
    ssfl_pkg::t_op                       r_op,         n_op;
    logic [IDX_W-1:0]                    r_idx,        n_idx;
    logic signed [ssfl_pkg::VALUE_W-1:0] r_value,      n_value;
    logic [CNT_W-1:0]                    r_free,       n_free;
    logic [CNT_W-1:0]                    r_hw,         n_hw;
    logic [CNT_W-1:0]                    r_live,       n_live;
    logic [IDX_W-1:0]                    r_ptr,        n_ptr;
    logic                                r_issue,      n_issue;
    logic                                r_rd_vld,     n_rd_vld;
    logic                                r_rd_last,    n_rd_last;
    logic [IDX_W-1:0]                    r_rd_addr,    n_rd_addr;
    logic [ssfl_pkg::SUM_W-1:0]          r_sum,        n_sum;
    ssfl_pkg::t_status                   r_res_status, n_res_status;
    logic [IDX_W-1:0]                    r_res_used,   n_res_used;
    logic [ssfl_pkg::SUM_W-1:0]          r_res_sum,    n_res_sum;
    logic                                r_o_valid,    n_o_valid;
    ssfl_pkg::t_status                   r_o_status,   n_o_status;
    logic [ssfl_pkg::INDEX_W-1:0]        r_o_used,     n_o_used;
    logic [ssfl_pkg::LIVE_W-1:0]         r_o_live,     n_o_live;
    logic [ssfl_pkg::SUM_W-1:0]          r_o_sum,      n_o_sum;

    logic                                req_fire;
    logic                                scan_last;
    logic [ssfl_pkg::SUM_W-1:0]          sum_term;

    assign i_req.ready      = (r_state == S_IDLE);
    assign req_fire         = i_req.valid && (r_state == S_IDLE);
    assign o_rsp.valid      = r_o_valid;
    assign o_rsp.status     = r_o_status;
    assign o_rsp.slot_used  = r_o_used;
    assign o_rsp.live_total = r_o_live;
    assign o_rsp.value_sum  = r_o_sum;

    assign scan_last = ((CNT_W'(r_ptr) + CNT_W'(1)) == r_hw);
    assign sum_term  = r_alive_q ? ssfl_pkg::SUM_W'(r_vmem_q) : '0;

    always_ff @(posedge i_clk) begin
        if (val_we) begin
            r_val_mem[val_waddr] <= val_wdata;
        end
        if (rd_en) begin
            r_vmem_q <= r_val_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (alive_we) begin
            r_alive_mem[alive_waddr] <= alive_wdata;
        end
        if (rd_en) begin
            r_alive_q <= r_alive_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (stk_we) begin
            r_stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            r_stk_q <= r_stk_mem[stk_raddr];
        end
    end

    always_comb begin
        val_we       = 1'b0;
        val_waddr    = '0;
        val_wdata    = r_value;
        alive_we     = 1'b0;
        alive_waddr  = '0;
        alive_wdata  = 1'b0;
        rd_en        = 1'b0;
        rd_addr      = '0;
        stk_we       = 1'b0;
        stk_waddr    = IDX_W'(r_free);
        stk_wdata    = r_idx;
        stk_re       = 1'b0;
        stk_raddr    = '0;

        n_state      = r_state;
        n_op         = r_op;
        n_idx        = r_idx;
        n_value      = r_value;
        n_free       = r_free;
        n_hw         = r_hw;
        n_live       = r_live;
        n_ptr        = r_ptr;
        n_issue      = r_issue;
        n_rd_vld     = 1'b0;
        n_rd_last    = r_rd_last;
        n_rd_addr    = r_rd_addr;
        n_sum        = r_sum;
        n_res_status = r_res_status;
        n_res_used   = r_res_used;
        n_res_sum    = r_res_sum;
        n_o_valid    = r_o_valid && !o_rsp.ready;
        n_o_status   = r_o_status;
        n_o_used     = r_o_used;
        n_o_live     = r_o_live;
        n_o_sum      = r_o_sum;

        case (r_state)
            S_IDLE: begin
                if (req_fire) begin
                    n_op         = i_req.operation;
                    n_idx        = IDX_W'(i_req.slot_index);
                    n_value      = i_req.value;
                    n_sum        = '0;
                    n_res_sum    = '0;
                    n_res_used   = '0;
                    n_res_status = ssfl_pkg::ST_OK;
                    case (i_req.operation)
                        ssfl_pkg::OP_INSERT: begin
                            if (r_free != '0) begin
                                stk_re    = 1'b1;
                                stk_raddr = IDX_W'(r_free - CNT_W'(1));
                                n_free    = r_free - CNT_W'(1);
                                n_state   = S_POP;
                            end else if (r_hw != CNT_W'(SLOT_COUNT)) begin
                                val_we      = 1'b1;
                                val_waddr   = IDX_W'(r_hw);
                                val_wdata   = i_req.value;
                                alive_we    = 1'b1;
                                alive_waddr = IDX_W'(r_hw);
                                alive_wdata = 1'b1;
                                n_hw        = r_hw + CNT_W'(1);
                                n_live      = r_live + CNT_W'(1);
                                n_res_used  = IDX_W'(r_hw);
                                n_state     = S_EMIT;
                            end else begin
                                n_res_status = ssfl_pkg::ST_FULL;
                                n_state      = S_EMIT;
                            end
                        end
                        ssfl_pkg::OP_ERASE_AT: begin
                            if (32'(i_req.slot_index) >= 32'(r_hw)) begin
                                n_res_status = ssfl_pkg::ST_BAD_SLOT;
                                n_state      = S_EMIT;
                            end else begin
                                rd_en   = 1'b1;
                                rd_addr = IDX_W'(i_req.slot_index);
                                n_state = S_CHK;
                            end
                        end
                        ssfl_pkg::OP_ERASE_FIRST, ssfl_pkg::OP_SUM: begin
                            if (r_hw == '0) begin
                                n_res_status = (i_req.operation == ssfl_pkg::OP_ERASE_FIRST)
                                             ? ssfl_pkg::ST_NONE_LIVE : ssfl_pkg::ST_OK;
                                n_state      = S_EMIT;
                            end else begin
                                n_ptr   = '0;
                                n_issue = 1'b1;
                                n_state = S_SCAN;
                            end
                        end
                        default: begin
                            n_state = S_EMIT;
                        end
                    endcase
                end
            end
            S_POP: begin
                val_we      = 1'b1;
                val_waddr   = r_stk_q;
                val_wdata   = r_value;
                alive_we    = 1'b1;
                alive_waddr = r_stk_q;
                alive_wdata = 1'b1;
                n_live      = r_live + CNT_W'(1);
                n_res_used  = r_stk_q;
                n_state     = S_EMIT;
            end
            S_CHK: begin
                if (!r_alive_q) begin
                    n_res_status = ssfl_pkg::ST_BAD_SLOT;
                end else begin
                    alive_we    = 1'b1;
                    alive_waddr = r_idx;
                    alive_wdata = 1'b0;
                    if (r_free != CNT_W'(SLOT_COUNT)) begin
                        stk_we    = 1'b1;
                        stk_wdata = r_idx;
                        n_free    = r_free + CNT_W'(1);
                    end
                    if (r_live != '0) begin
                        n_live = r_live - CNT_W'(1);
                    end
                    n_res_used = r_idx;
                end
                n_state = S_EMIT;
            end
            S_SCAN: begin
                if (r_issue) begin
                    rd_en     = 1'b1;
                    rd_addr   = r_ptr;
                    n_ptr     = r_ptr + IDX_W'(1);
                    n_rd_addr = r_ptr;
                    n_rd_last = scan_last;
                    n_issue   = !scan_last;
                    n_rd_vld  = 1'b1;
                end
                if (r_rd_vld) begin
                    if (r_op == ssfl_pkg::OP_ERASE_FIRST) begin
                        if (r_alive_q) begin
                            alive_we    = 1'b1;
                            alive_waddr = r_rd_addr;
                            alive_wdata = 1'b0;
                            if (r_free != CNT_W'(SLOT_COUNT)) begin
                                stk_we    = 1'b1;
                                stk_wdata = r_rd_addr;
                                n_free    = r_free + CNT_W'(1);
                            end
                            if (r_live != '0) begin
                                n_live = r_live - CNT_W'(1);
                            end
                            n_res_used   = r_rd_addr;
                            n_res_status = ssfl_pkg::ST_OK;
                            n_issue      = 1'b0;
                            n_rd_vld     = 1'b0;
                            n_state      = S_EMIT;
                        end else if (r_rd_last) begin
                            n_res_status = ssfl_pkg::ST_NONE_LIVE;
                            n_issue      = 1'b0;
                            n_rd_vld     = 1'b0;
                            n_state      = S_EMIT;
                        end
                    end else begin
                        n_sum = r_sum + sum_term;
                        if (r_rd_last) begin
                            n_res_sum = r_sum + sum_term;
                            n_issue   = 1'b0;
                            n_rd_vld  = 1'b0;
                            n_state   = S_EMIT;
                        end
                    end
                end
            end
            S_EMIT: begin
                if (!r_o_valid || o_rsp.ready) begin
                    n_o_valid  = 1'b1;
                    n_o_status = r_res_status;
                    n_o_used   = ssfl_pkg::INDEX_W'(r_res_used);
                    n_o_live   = ssfl_pkg::LIVE_W'(r_live);
                    n_o_sum    = r_res_sum;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_op         <= n_op;
        r_idx        <= n_idx;
        r_value      <= n_value;
        r_ptr        <= n_ptr;
        r_rd_last    <= n_rd_last;
        r_rd_addr    <= n_rd_addr;
        r_sum        <= n_sum;
        r_res_status <= n_res_status;
        r_res_used   <= n_res_used;
        r_res_sum    <= n_res_sum;
        r_o_status   <= n_o_status;
        r_o_used     <= n_o_used;
        r_o_live     <= n_o_live;
        r_o_sum      <= n_o_sum;
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_free    <= '0;
            r_hw      <= '0;
            r_live    <= '0;
            r_issue   <= 1'b0;
            r_rd_vld  <= 1'b0;
            r_o_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_free    <= n_free;
            r_hw      <= n_hw;
            r_live    <= n_live;
            r_issue   <= n_issue;
            r_rd_vld  <= n_rd_vld;
            r_o_valid <= n_o_valid;
        end
    end

endmodule
